/* hdl/gfr_pkg.sv */
// ----------------------------------------------------------------------------
// gfr_pkg
// Shared types and constants for the gamepad frame receiver.
// ----------------------------------------------------------------------------
package gfr_pkg;

   localparam int FRAME_BYTES = 32;
   localparam logic [31:0] CRC_POLY = 32'h04C11DB7;

   localparam logic [1:0] CSR_DEAD_INNER = 2'd0;
   localparam logic [1:0] CSR_DEAD_OUTER = 2'd1;
   localparam logic [1:0] CSR_FULL_SCALE = 2'd2;
   localparam logic [1:0] CSR_TIMEOUT    = 2'd3;

   localparam logic [1:0] LINK_DOWN  = 2'd0;
   localparam logic [1:0] LINK_RADIO = 2'd1;
   localparam logic [1:0] LINK_FULL  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CRC,
      ST_CHECK,
      ST_SHAPE,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take;      // latch request, update position and store or idle count
      logic crc_start; // preset crc to all ones, clear its counter
      logic crc_step;  // one crc bit step
      logic check;     // compare crc and update link state
      logic shp_start; // start the stick shaper
      logic shp_step;  // one shaper step
      logic finish;    // timeout update and output registers
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic frame_end; // accepted byte completed a frame
      logic crc_last;  // last crc step
      logic shp_last;  // last shaper step
   } stat_type;

endpackage

/* hdl/gfr_datapath.sv */
// ----------------------------------------------------------------------------
// gfr_datapath
// Frame store, bit-serial crc, unpacking and serial stick shaping.
// ----------------------------------------------------------------------------
module gfr_datapath import gfr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  ctrl_type          ctrl,
   output stat_type          stat,
   input  logic              in_type,
   input  logic [7:0]        in_byte,
   input  logic [14:0]       dead_inner,
   input  logic [14:0]       dead_outer,
   input  logic [14:0]       full_scale,
   input  logic [15:0]       timeout_ticks,
   output logic              o_done,
   output logic              o_ok,
   output logic [15:0]       o_buttons,
   output logic [7:0]        o_trig_l,
   output logic [7:0]        o_trig_r,
   output logic signed [15:0] o_stick [4],
   output logic [1:0]        o_link,
   output logic [15:0]       o_errors
);

   localparam int PW = $clog2(FRAME_BYTES);

   logic [7:0]  store_ff [FRAME_BYTES];
   logic [PW-1:0] pos_ff;
   logic        type_ff, end_ff;
   logic [31:0] crc_ff;
   logic [7:0]  cnt_ff;          // word and bit counter for crc
   logic        ok_ff;
   logic [15:0] btn_ff, err_ff, idle_ff;
   logic [7:0]  trl_ff, trr_ff;
   logic [15:0] raw_ff [4];
   logic [1:0]  link_ff;

   // shaper: one stick, restoring division one quotient bit a step
   logic [1:0]  sidx_ff;
   logic [4:0]  sbit_ff;
   logic        sphase_ff;       // 0 setup, 1 dividing
   logic [29:0] num_ff;          // |num|*scale, below 2^30
   logic [30:0] rem_ff;
   logic [29:0] quo_ff;
   logic        neg_ff, mode_div_ff;
   logic signed [15:0] res_ff;
   logic signed [15:0] sh_ff [4];

   logic        done_ff, okout_ff;
   logic [15:0] obtn_ff;

   logic [PW-1:0] wpos;
   logic [PW-1:0] pos_in;
   always_comb begin
      wpos = (in_byte == 8'd0) ? '0 : pos_ff;
      pos_in = wpos + 1'b1;
   end

   // crc word fetch: bytes 28..31 replaced by their index
   logic [2:0] widx;
   logic [4:0] bidx;
   logic [31:0] word;
   always_comb begin
      widx = cnt_ff[7:5];
      bidx = cnt_ff[4:0];
      for (int k = 0; k < 4; k++) begin
         if (widx == 3'd7)
            word[8*k +: 8] = 8'(28 + k);
         else
            word[8*k +: 8] = store_ff[{widx, 2'(k)}];
      end
   end

   logic [31:0] crc_x, crc_n;
   always_comb begin
      crc_x = (bidx == 5'd0) ? (crc_ff ^ word) : crc_ff;
      crc_n = crc_x[31] ? ({crc_x[30:0], 1'b0} ^ CRC_POLY) : {crc_x[30:0], 1'b0};
   end

   function automatic logic [7:0] fix(input logic [7:0] b);
      fix = (b == 8'd0) ? 8'd1 : b;
   endfunction

   logic [31:0] mine, theirs;
   always_comb begin
      mine = {fix(crc_ff[31:24]), fix(crc_ff[23:16]), fix(crc_ff[15:8]), fix(crc_ff[7:0])};
      theirs = {store_ff[28], store_ff[29], store_ff[30], store_ff[31]};
   end

   function automatic logic [15:0] nib4(input int first, input logic [7:0] s [FRAME_BYTES]);
      nib4 = {s[first+3][3:0], s[first+2][3:0], s[first+1][3:0], s[first][3:0]};
   endfunction

   // shaper setup
   logic signed [16:0] v, vin, vout;
   logic [15:0] mag;
   logic [15:0] span;
   logic [14:0] mnum;
   always_comb begin
      v    = 17'(signed'(raw_ff[sidx_ff]));
      vin  = 17'(dead_inner);
      vout = 17'(dead_outer);
      mag  = v[16] ? 16'(-v) : 16'(v);
      mnum = 15'(mag - {1'b0, dead_inner});
      span = {1'b0, dead_outer} - {1'b0, dead_inner};
   end

   logic [30:0] rem_sh;
   logic [30:0] rem_sub;
   always_comb begin
      rem_sh  = {rem_ff[29:0], num_ff[29]};
      rem_sub = rem_sh - {15'd0, span};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; end_ff <= 1'b0; type_ff <= 1'b0;
         btn_ff <= '0; trl_ff <= '0; trr_ff <= '0;
         for (int k = 0; k < 4; k++) begin
            raw_ff[k] <= '0;
            sh_ff[k] <= '0;
         end
         link_ff <= LINK_DOWN; err_ff <= '0; idle_ff <= '0; ok_ff <= 1'b0;
         done_ff <= 1'b0; okout_ff <= 1'b0; obtn_ff <= '0;
         sidx_ff <= '0; sphase_ff <= 1'b0; sbit_ff <= '0;
      end else begin
         if (ctrl.take) begin
            type_ff <= in_type;
            ok_ff <= 1'b0;
            end_ff <= 1'b0;
            if (!in_type) begin
               store_ff[wpos] <= in_byte;
               pos_ff <= pos_in;
               end_ff <= (pos_in == '0);
            end else if (idle_ff != 16'hFFFF) begin
               idle_ff <= idle_ff + 16'd1;
            end
         end
         if (ctrl.crc_start) begin
            crc_ff <= '1;
            cnt_ff <= '0;
         end
         if (ctrl.crc_step) begin
            crc_ff <= crc_n;
            cnt_ff <= cnt_ff + 8'd1;
         end
         if (ctrl.check) begin
            if (mine == theirs) begin
               ok_ff <= 1'b1;
               btn_ff <= nib4(1, store_ff);
               trl_ff <= {store_ff[6][3:0], store_ff[5][3:0]};
               trr_ff <= {store_ff[8][3:0], store_ff[7][3:0]};
               for (int k = 0; k < 4; k++) raw_ff[k] <= nib4(9 + 4*k, store_ff);
               link_ff <= (store_ff[25] == 8'd25 && store_ff[26] == 8'd26) ?
                          LINK_FULL : LINK_RADIO;
               idle_ff <= '0;
            end else if (err_ff != 16'hFFFF) begin
               err_ff <= err_ff + 16'd1;
            end
            for (int k = 28; k < 32; k++) store_ff[k] <= mine[8*(31-k) +: 8];
         end
         if (ctrl.shp_start) begin
            sidx_ff <= '0;
            sphase_ff <= 1'b0;
         end
         if (ctrl.shp_step) begin
            if (!sphase_ff) begin
               neg_ff <= v[16];
               mode_div_ff <= 1'b0;
               if (v >= -vin && v <= vin) res_ff <= '0;
               else if (v < -vout) res_ff <= -16'(signed'({1'b0, full_scale}));
               else if (v > vout) res_ff <= 16'(signed'({1'b0, full_scale}));
               else begin
                  mode_div_ff <= 1'b1;
                  res_ff <= '0;
               end
               num_ff <= 30'(mnum * full_scale);
               rem_ff <= '0;
               quo_ff <= '0;
               sbit_ff <= '0;
               sphase_ff <= 1'b1;
            end else begin
               if (mode_div_ff) begin
                  num_ff <= {num_ff[28:0], 1'b0};
                  if (!rem_sub[30]) begin
                     rem_ff <= rem_sub;
                     quo_ff <= {quo_ff[28:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh;
                     quo_ff <= {quo_ff[28:0], 1'b0};
                  end
               end
               sbit_ff <= sbit_ff + 5'd1;
               if (sbit_ff == 5'd30) begin
                  if (mode_div_ff)
                     sh_ff[sidx_ff] <= neg_ff ? -16'(quo_ff) : 16'(quo_ff);
                  else
                     sh_ff[sidx_ff] <= res_ff;
                  sidx_ff <= sidx_ff + 2'd1;
                  sphase_ff <= 1'b0;
               end
            end
         end
         if (ctrl.finish) begin
            done_ff <= end_ff & ~type_ff;
            okout_ff <= ok_ff;
            if (idle_ff > timeout_ticks) begin
               link_ff <= LINK_DOWN;
               obtn_ff <= '0;
            end else begin
               obtn_ff <= (link_ff == LINK_DOWN) ? 16'd0 : btn_ff;
            end
         end
      end
   end

   always_comb begin
      stat.frame_end = end_ff & ~type_ff;
      stat.crc_last  = (cnt_ff == 8'd255);
      stat.shp_last  = sphase_ff && (sbit_ff == 5'd30) && (sidx_ff == 2'd3);
      o_done = done_ff;
      o_ok = okout_ff;
      o_buttons = obtn_ff;
      o_trig_l = trl_ff;
      o_trig_r = trr_ff;
      for (int k = 0; k < 4; k++) o_stick[k] = sh_ff[k];
      o_link = link_ff;
      o_errors = err_ff;
   end

endmodule

/* hdl/gfr_control.sv */
// ----------------------------------------------------------------------------
// gfr_control
// Sequencer for request intake, crc, check, shaping and response.
// ----------------------------------------------------------------------------
module gfr_control import gfr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output ctrl_type ctrl,
   input  stat_type stat
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      ctrl = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctrl.take = 1'b1;
               ctrl.crc_start = 1'b1;
               state_in = ST_CRC;
            end
         end
         ST_CRC: begin
            if (!stat.frame_end) begin
               ctrl.shp_start = 1'b1;
               state_in = ST_SHAPE;
            end else begin
               ctrl.crc_step = 1'b1;
               if (stat.crc_last) state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            ctrl.check = 1'b1;
            ctrl.shp_start = 1'b1;
            state_in = ST_SHAPE;
         end
         ST_SHAPE: begin
            ctrl.shp_step = 1'b1;
            if (stat.shp_last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            ctrl.finish = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* hdl/gfr_outreg.sv */
// ----------------------------------------------------------------------------
// gfr_outreg
// Response handshake register: holds valid until the response is taken.
// ----------------------------------------------------------------------------
module gfr_outreg import gfr_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic load,
   input  logic rsp_stall,
   output logic rsp_valid,
   output logic busy
);
   logic valid_ff;
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (load) valid_ff <= 1'b1;
      else if (!rsp_stall) valid_ff <= 1'b0;
   end
   assign rsp_valid = valid_ff;
   assign busy = valid_ff & rsp_stall;
endmodule

/* hdl/gamepad_frame_receiver.sv */
// ----------------------------------------------------------------------------
// gamepad_frame_receiver
// Frame receiver for a serial gamepad link with crc check and stick shaping.
// ----------------------------------------------------------------------------
// a tick or mid-frame byte goes straight to shaping, a frame-ending byte first to crc and check
// one request at a time, the next taken only once the last is through;
//   the serial crc (256 bit steps) and the serial shaper (4 sticks in turn) set how soon that is
// reset: synchronous, control state, link, error and idle counters clear
// a new request waits while a response is still stalled
module gamepad_frame_receiver import gfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_frame_done,
   output logic        rsp_crc_ok,
   output logic [15:0] rsp_buttons,
   output logic [7:0]  rsp_trig_left,
   output logic [7:0]  rsp_trig_right,
   output logic signed [15:0] rsp_stick_lx,
   output logic signed [15:0] rsp_stick_ly,
   output logic signed [15:0] rsp_stick_rx,
   output logic signed [15:0] rsp_stick_ry,
   output logic [1:0]  rsp_link_state,
   output logic [15:0] rsp_bad_frames,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   ctrl_type ctrl;
   stat_type stat;
   logic [14:0] inner_ff, outer_ff, scale_ff;
   logic [15:0] tmo_ff;
   logic busy, stall_c;
   logic signed [15:0] stick [4];

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff <= 15'd1000; outer_ff <= 15'd30000;
         scale_ff <= 15'd1000; tmo_ff <= 16'd100;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DEAD_INNER: inner_ff <= csr_data[14:0];
            CSR_DEAD_OUTER: outer_ff <= csr_data[14:0];
            CSR_FULL_SCALE: scale_ff <= csr_data[14:0];
            CSR_TIMEOUT:    tmo_ff <= csr_data;
            default: ;
         endcase
      end
   end

   gfr_control u_ctl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid & ~busy), .req_stall(stall_c),
      .ctrl(ctrl), .stat(stat)
   );
   assign req_stall = stall_c | busy;

   gfr_outreg u_out (
      .clock(clock), .reset(reset), .load(ctrl.finish),
      .rsp_stall(rsp_stall), .rsp_valid(rsp_valid), .busy(busy)
   );

   gfr_datapath u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .in_type(req_type), .in_byte(req_rx_byte),
      .dead_inner(inner_ff), .dead_outer(outer_ff), .full_scale(scale_ff),
      .timeout_ticks(tmo_ff),
      .o_done(rsp_frame_done), .o_ok(rsp_crc_ok), .o_buttons(rsp_buttons),
      .o_trig_l(rsp_trig_left), .o_trig_r(rsp_trig_right), .o_stick(stick),
      .o_link(rsp_link_state), .o_errors(rsp_bad_frames)
   );

   assign rsp_stick_lx = stick[0];
   assign rsp_stick_ly = stick[1];
   assign rsp_stick_rx = stick[2];
   assign rsp_stick_ry = stick[3];

   // a response is never loaded over one still waiting
   property p_no_overrun;
      @(posedge clock) disable iff (reset) ctrl.finish |-> !(rsp_valid && rsp_stall);
   endproperty
   a_no_overrun: assert property (p_no_overrun) else $error("response overrun");

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> req_stall) else $error("request taken while busy");

   a_link_zero_btn: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_link_state == LINK_DOWN) |-> rsp_buttons == 16'd0)
      else $error("buttons while disconnected");

   a_ok_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_crc_ok) |-> rsp_frame_done) else $error("ok without frame");

endmodule

/* verif/gfr_checker.sv */
// ----------------------------------------------------------------------------
// gfr_checker
// Watches the request, response and register channels of the gamepad frame
// receiver, predicts every response from its own copy of the frame state and
// compares field by field, oldest prediction first.
// ----------------------------------------------------------------------------
module gfr_checker import gfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_frame_done,
   input  logic        rsp_crc_ok,
   input  logic [15:0] rsp_buttons,
   input  logic [7:0]  rsp_trig_left,
   input  logic [7:0]  rsp_trig_right,
   input  logic [15:0] rsp_stick_lx,
   input  logic [15:0] rsp_stick_ly,
   input  logic [15:0] rsp_stick_rx,
   input  logic [15:0] rsp_stick_ry,
   input  logic [1:0]  rsp_link_state,
   input  logic [15:0] rsp_bad_frames,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        done;
      logic        ok;
      logic [15:0] buttons;
      logic [7:0]  trig_l;
      logic [7:0]  trig_r;
      logic [15:0] stick[4];
      logic [1:0]  link;
      logic [15:0] errors;
   } pad_report_type;

   pad_report_type report_q[$];

   logic [14:0] dz_inner, dz_outer, out_scale;
   logic [15:0] idle_limit;
   logic [4:0]  wr_pos;
   logic [7:0]  frame_buf[32];
   logic [15:0] btn_bits, err_cnt, idle_cnt;
   logic [7:0]  trig_val[2];
   logic [15:0] stick_raw[4];
   logic [1:0]  link_st;

   assign pending = report_q.size();

   function automatic logic [31:0] frame_crc32();
      logic [31:0] crc, word;
      crc = 32'hFFFF_FFFF;
      for (int w = 0; w < 8; w++) begin
         word = {frame_buf[4*w+3], frame_buf[4*w+2], frame_buf[4*w+1], frame_buf[4*w]};
         crc ^= word;
         for (int b = 0; b < 32; b++)
            crc = crc[31] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
      end
      return crc;
   endfunction

   function automatic logic [15:0] nibbles(int first, int count);
      logic [15:0] v;
      v = '0;
      for (int k = 0; k < count; k++)
         v[4*k +: 4] = frame_buf[first + k][3:0];
      return v;
   endfunction

   function automatic logic [15:0] deadzone(logic [15:0] raw);
      longint v, lo, hi, sc, r;
      v  = longint'($signed(raw));
      lo = dz_inner;
      hi = dz_outer;
      sc = out_scale;
      if (v >= -lo && v <= lo) r = 0;
      else if (v < -hi) r = -sc;
      else if (v > hi) r = sc;
      else if (hi - lo > 0) r = ((v > 0) ? v - lo : v + lo) * sc / (hi - lo);
      else r = 0;
      return r[15:0];
   endfunction

   task automatic predict_request(logic is_tick, logic [7:0] data);
      pad_report_type exp_r;
      logic [31:0]  theirs, mine;
      logic [7:0]   by;
      exp_r.done = 0;
      exp_r.ok   = 0;
      if (!is_tick) begin
         if (data == 0) wr_pos = 0;
         frame_buf[wr_pos] = data;
         wr_pos++;
         if (wr_pos == 0) begin
            exp_r.done = 1;
            theirs = {frame_buf[28], frame_buf[29], frame_buf[30], frame_buf[31]};
            for (int k = 0; k < 4; k++) frame_buf[28+k] = 8'(28 + k);
            mine = frame_crc32();
            for (int k = 0; k < 4; k++) begin
               by = mine[31-8*k -: 8];
               if (by == 0) by = 1;
               frame_buf[28+k] = by;
               mine[31-8*k -: 8] = by;
            end
            if (theirs == mine) begin
               exp_r.ok    = 1;
               btn_bits    = nibbles(1, 4);
               trig_val[0] = 8'(nibbles(5, 2));
               trig_val[1] = 8'(nibbles(7, 2));
               for (int k = 0; k < 4; k++) stick_raw[k] = nibbles(9 + 4*k, 4);
               link_st  = (frame_buf[25] == 25 && frame_buf[26] == 26) ? LINK_FULL : LINK_RADIO;
               idle_cnt = 0;
            end else if (err_cnt != 16'hFFFF) begin
               err_cnt++;
            end
         end
      end else if (idle_cnt != 16'hFFFF) begin
         idle_cnt++;
      end
      if (idle_cnt > idle_limit) link_st = LINK_DOWN;
      exp_r.buttons = (link_st == LINK_DOWN) ? 16'h0 : btn_bits;
      exp_r.trig_l  = trig_val[0];
      exp_r.trig_r  = trig_val[1];
      for (int k = 0; k < 4; k++) exp_r.stick[k] = deadzone(stick_raw[k]);
      exp_r.link   = link_st;
      exp_r.errors = err_cnt;
      report_q.push_back(exp_r);
   endtask

   task automatic cmp(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         report_q.delete();
         fail_count = 0;
         dz_inner = 1000; dz_outer = 30000; out_scale = 1000; idle_limit = 100;
         wr_pos = 0; btn_bits = 0; err_cnt = 0; idle_cnt = 0; link_st = LINK_DOWN;
         trig_val = '{default: 0};
         stick_raw = '{default: 0};
         frame_buf = '{default: 0};
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEAD_INNER: dz_inner = csr_data[14:0];
               CSR_DEAD_OUTER: dz_outer = csr_data[14:0];
               CSR_FULL_SCALE: out_scale = csr_data[14:0];
               CSR_TIMEOUT:    idle_limit = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (report_q.size() == 0) begin
               fail_count++;
               $display("%0t: response with none expected, expected none, got link %0d",
                        $time, rsp_link_state);
            end else begin
               pad_report_type e;
               e = report_q.pop_front();
               cmp("frame_done", 16'(e.done), 16'(rsp_frame_done));
               cmp("crc_ok", 16'(e.ok), 16'(rsp_crc_ok));
               cmp("buttons", e.buttons, rsp_buttons);
               cmp("trig_left", 16'(e.trig_l), 16'(rsp_trig_left));
               cmp("trig_right", 16'(e.trig_r), 16'(rsp_trig_right));
               cmp("stick_lx", e.stick[0], rsp_stick_lx);
               cmp("stick_ly", e.stick[1], rsp_stick_ly);
               cmp("stick_rx", e.stick[2], rsp_stick_rx);
               cmp("stick_ry", e.stick[3], rsp_stick_ry);
               cmp("link_state", 16'(e.link), 16'(rsp_link_state));
               cmp("bad_frames", e.errors, rsp_bad_frames);
            end
         end
         if (req_valid && !req_stall) predict_request(req_type, req_rx_byte);
      end
   end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Regression for the gamepad frame receiver: directed frames, then random
// well-formed, corrupted and noisy byte streams with timer ticks, over several
// deadzone and timeout settings and with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top import gfr_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0, req_type = 0;
   logic [7:0]  req_rx_byte = 0;
   logic        req_stall, rsp_valid;
   logic        rsp_stall = 0;
   logic        rsp_frame_done, rsp_crc_ok;
   logic [15:0] rsp_buttons, rsp_bad_frames;
   logic [7:0]  rsp_trig_left, rsp_trig_right;
   logic signed [15:0] rsp_stick_lx, rsp_stick_ly, rsp_stick_rx, rsp_stick_ry;
   logic [1:0]  rsp_link_state;
   logic        csr_valid = 0, csr_ready;
   logic [1:0]  csr_index = 0;
   logic [15:0] csr_data = 0;
   int          fail_count, pending;

   int          snd_idle = 0, rcv_idle = 0;
   logic        hold_rsp = 0;
   int          stall_cnt = 0;
   int          cur_inner = 1000, cur_outer = 30000;
   int          phase_items;
   logic [7:0]  frm[32];

   always #5 clock = ~clock;

   gamepad_frame_receiver u_dut (.*);

   gfr_checker u_checker (.*);

   // receiver side: random stalls, or one long hold when asked
   initial forever begin
      @(negedge clock);
      if (hold_rsp) begin
         rsp_stall = 1;
         repeat (400) @(negedge clock);
         hold_rsp = 0;
      end
      rsp_stall = ($urandom_range(99) < rcv_idle);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         stall_cnt <= 0;
      else
         stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= WATCHDOG_LIMIT) begin
         $display("gamepad_frame_receiver regression: fail");
         $finish;
      end
   end

   task automatic send_req(logic typ, logic [7:0] data);
      while ($urandom_range(99) < snd_idle) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid   = 1;
      req_type    = typ;
      req_rx_byte = data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      req_valid = 0;
      phase_items++;
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_valid = 1;
      csr_index = idx;
      csr_data  = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic drain();
      while (pending != 0) @(negedge clock);
   endtask

   // stick value aimed at the deadzone edges half the time
   function automatic logic [15:0] pick_stick();
      int d;
      d = $urandom_range(2) - 1;
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'(cur_inner + d);
         3: return 16'(-(cur_inner + d));
         4: return 16'(cur_outer + d);
         5: return 16'(-(cur_outer + d));
         default: return 16'($urandom);
      endcase
   endfunction

   // nonzero bytes carry the nibble fields, zero only at the start
   task automatic build_frame(logic [15:0] btn, logic [15:0] trg, logic [15:0] stk[4],
                              logic full_link, logic corrupt);
      logic [63:0] body;
      logic [31:0] crc;
      int          k;
      body = {stk[3], stk[2], stk[1], stk[0]};
      frm[0] = 0;
      for (int i = 0; i < 4; i++) frm[1+i] = {4'($urandom_range(15, 1)), btn[4*i +: 4]};
      for (int i = 0; i < 4; i++) frm[5+i] = {4'($urandom_range(15, 1)), trg[4*i +: 4]};
      for (int i = 0; i < 16; i++) frm[9+i] = {4'($urandom_range(15, 1)), body[4*i +: 4]};
      frm[25] = full_link ? 8'd25 : 8'($urandom_range(255, 1));
      frm[26] = full_link ? 8'd26 : 8'($urandom_range(255, 27));
      frm[27] = 8'($urandom_range(255, 1));
      for (int i = 0; i < 4; i++) frm[28+i] = 8'(28 + i);
      crc = 32'hFFFF_FFFF;
      for (int w = 0; w < 8; w++) begin
         crc ^= {frm[4*w+3], frm[4*w+2], frm[4*w+1], frm[4*w]};
         for (int b = 0; b < 32; b++) crc = crc[31] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
      end
      for (int i = 0; i < 4; i++) begin
         frm[28+i] = crc[31-8*i -: 8];
         if (frm[28+i] == 0) frm[28+i] = 1;
      end
      if (corrupt) begin
         k = $urandom_range(31, 1);
         frm[k] = frm[k] ^ 8'($urandom_range(255, 1));
         if (frm[k] == 0) frm[k] = 8'hFF;
      end
   endtask

   task automatic send_frame(int tick_pct);
      for (int i = 0; i < 32; i++) begin
         while ($urandom_range(99) < tick_pct) send_req(1, 8'($urandom));
         send_req(0, frm[i]);
      end
   endtask

   task automatic random_frame(logic corrupt);
      logic [15:0] stk[4];
      for (int i = 0; i < 4; i++) stk[i] = pick_stick();
      build_frame(16'($urandom), 16'($urandom), stk, $urandom_range(3) != 0, corrupt);
      send_frame($urandom_range(1) ? 0 : 8);
   endtask

   task automatic configure(int inner, int outer, int scale, int tmo);
      drain();
      repeat (400) @(negedge clock);
      write_reg(CSR_DEAD_INNER, 16'(inner));
      write_reg(CSR_DEAD_OUTER, 16'(outer));
      write_reg(CSR_FULL_SCALE, 16'(scale));
      write_reg(CSR_TIMEOUT, 16'(tmo));
      cur_inner = inner;
      cur_outer = outer;
   endtask

   initial begin
      logic [15:0] stk[4];
      int          sel;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: extreme fields, an abandoned partial frame, restart, ticks
      phase_items = 0;
      stk = '{16'h8000, 16'h7FFF, 16'd1001, 16'hFC17};
      build_frame(16'hFFFF, 16'hFFFF, stk, 1, 0);
      send_frame(0);
      stk = '{16'h0000, 16'hFFFF, 16'd1000, 16'hFC18};
      build_frame(16'h0000, 16'h0000, stk, 0, 1);
      for (int i = 0; i < 6; i++) send_req(0, frm[i]);
      send_req(1, 8'hFF);
      build_frame(16'h0000, 16'h0000, stk, 0, 0);
      send_frame(0);
      send_req(1, 8'h00);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            1: configure(0, 32767, 32767, 65535);
            2: configure(32767, 1, 0, 0);
            3: configure(2000, 2001, 500, 3);
            4: configure(100, 20000, 12345, 40);
            5: configure($urandom_range(5000), $urandom_range(32767, 5001),
                         $urandom_range(32767), $urandom_range(20));
            default: ;
         endcase
         case (phase / 2)
            0: begin snd_idle = 38; rcv_idle = 87; end
            1: begin snd_idle = 87; rcv_idle = 38; end
            default: begin snd_idle = 0; rcv_idle = 0; end
         endcase
         if (phase == 1 || phase == 4) hold_rsp = 1;
         phase_items = 0;
         while (phase_items < 150) begin
            sel = $urandom_range(99);
            if (sel < 65) random_frame(0);
            else if (sel < 80) random_frame(1);
            else if (sel < 90) repeat ($urandom_range(12, 1)) send_req(1, 8'($urandom));
            else repeat ($urandom_range(10, 1))
               send_req(0, $urandom_range(3) == 0 ? 8'h00 : 8'($urandom));
         end
      end

      drain();
      repeat (500) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("gamepad_frame_receiver regression: pass");
      else
         $display("gamepad_frame_receiver regression: fail");
      $finish;
   end

endmodule

/* sim.f */
hdl/gfr_pkg.sv
hdl/gfr_datapath.sv
hdl/gfr_control.sv
hdl/gfr_outreg.sv
hdl/gamepad_frame_receiver.sv
verif/gfr_checker.sv
verif/tb_top.sv
